@@ rtl/utf8_to_lcd_charset_framer_top_assert.svh @@
// ----------------------------------------------------------------------------
// utf8_to_lcd_charset_framer_top_assert.svh
// Assertion macros used by the framer top level.
// ----------------------------------------------------------------------------
`ifndef UTF8_TO_LCD_CHARSET_FRAMER_TOP_ASSERT_SVH
`define UTF8_TO_LCD_CHARSET_FRAMER_TOP_ASSERT_SVH

// Same-cycle implication, clocked on clk_i, quiet while in reset.
`define U2LCD_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, clocked on clk_i, quiet while in reset.
`define U2LCD_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ rtl/u2lcd_pkg.sv @@
// ----------------------------------------------------------------------------
// u2lcd_pkg
// Types and constants of the UTF-8 to LCD charset framer.
// ----------------------------------------------------------------------------
package u2lcd_pkg;

  // Configuration register indexes
  localparam logic CfgDataCtl  = 1'b0;
  localparam logic CfgContMask = 1'b1;

  // Register reset values
  localparam logic [7:0] DataCtlReset  = 8'h40;
  localparam logic [7:0] ContMaskReset = 8'h80;

  // Half-width katakana block and its display codes
  localparam logic [15:0] KanaFirst  = 16'hFF61;
  localparam logic [15:0] KanaLast   = 16'hFF9F;
  // 0xA1 - 0x61, modulo 256
  localparam logic [7:0]  KanaOffset = 8'h40;
  localparam logic [7:0]  UnknownCode = 8'h3F;  // '?'

  // Lead byte classes
  localparam logic [7:0] Lead4Mask = 8'hF8;
  localparam logic [7:0] Lead4Code = 8'hF0;
  localparam logic [7:0] Lead3Mask = 8'hF0;
  localparam logic [7:0] Lead3Code = 8'hE0;
  localparam logic [7:0] Lead2Mask = 8'hE0;
  localparam logic [7:0] Lead2Code = 8'hC0;
  localparam logic [7:0] ContBits  = 8'h3F;
  localparam logic [7:0] Lead3Bits = 8'h0F;

  // Output queue geometry
  localparam int unsigned QDepth = 4;
  localparam int unsigned QPtrW  = 2;
  localparam int unsigned QCntW  = 3;

  // One result word
  typedef struct packed {
    logic [7:0] ctrl;
    logic [7:0] data;
    logic       eom;
  } res_t;

  // Words produced by one byte, in order
  typedef struct packed {
    logic [1:0] num;
    res_t       w0;
    res_t       w1;
  } push_t;

  // Queue status seen by the top level
  typedef struct packed {
    logic [QCntW-1:0] count;
    logic             room;
  } qstat_t;

endpackage

@@ rtl/u2lcd_decode.sv @@
// ----------------------------------------------------------------------------
// u2lcd_decode
// UTF-8 byte decoder: running sequence state, katakana mapping, hold-back
// of one code and framing of control/data words.
// ----------------------------------------------------------------------------
module u2lcd_decode #(
  parameter int unsigned ROW_CHARS = 16
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             fire_i,
  input  logic [7:0]       byte_i,
  input  logic             last_i,
  input  logic [7:0]       data_ctl_i,
  input  logic [7:0]       cont_mask_i,
  output u2lcd_pkg::push_t push_o
);
  import u2lcd_pkg::*;

  localparam logic [4:0] RowLim = 5'(ROW_CHARS);
  localparam logic [4:0] CntMax = 5'd31;

  logic [1:0] skip_q, skip_d;
  logic [1:0] coll_q, coll_d;
  logic [9:0] part_q, part_d;
  logic [4:0] cnt_q,  cnt_d;
  logic       hv_q,   hv_d;
  logic [7:0] hc_q,   hc_d;

  logic        acc_main, acc_trunc, acc;
  logic [7:0]  code_main, code;
  logic [15:0] cp;
  logic        hv_after;
  logic [7:0]  hc_after;
  res_t        w_cont, w_final;

  assign cp = {part_q, byte_i[5:0]};

  // Sequence state and the code produced by this byte
  always_comb begin
    skip_d    = skip_q;
    coll_d    = coll_q;
    part_d    = part_q;
    acc_main  = 1'b0;
    code_main = byte_i;
    if (skip_q != 2'd0) begin
      skip_d = skip_q - 2'd1;
    end else if (coll_q == 2'd2) begin
      part_d = {part_q[3:0], byte_i[5:0]};
      coll_d = 2'd1;
    end else if (coll_q == 2'd1) begin
      coll_d   = 2'd0;
      part_d   = '0;
      acc_main = 1'b1;
      if (cp >= KanaFirst && cp <= KanaLast) begin
        code_main = cp[7:0] + KanaOffset;
      end else begin
        code_main = UnknownCode;
      end
    end else if (cnt_q < RowLim) begin
      if ((byte_i & Lead4Mask) == Lead4Code) begin
        acc_main  = 1'b1;
        code_main = UnknownCode;
        skip_d    = 2'd3;
      end else if ((byte_i & Lead3Mask) == Lead3Code) begin
        part_d = {6'd0, byte_i[3:0] & Lead3Bits[3:0]};
        coll_d = 2'd2;
      end else if ((byte_i & Lead2Mask) == Lead2Code) begin
        acc_main  = 1'b1;
        code_main = UnknownCode;
        skip_d    = 2'd1;
      end else begin
        acc_main = 1'b1;
      end
    end
  end

  // A three-byte character cut off by the end of the string gives '?'
  assign acc_trunc = last_i && (coll_d != 2'd0);
  assign acc       = acc_main || acc_trunc;
  assign code      = acc_main ? code_main : UnknownCode;
  assign hv_after  = acc || hv_q;
  assign hc_after  = acc ? code : hc_q;

  assign w_cont  = '{ctrl: data_ctl_i | cont_mask_i, data: hc_q, eom: 1'b0};
  assign w_final = '{ctrl: data_ctl_i, data: hc_after, eom: 1'b1};

  // Words released by this byte
  always_comb begin
    push_o = '{num: 2'd0, w0: w_final, w1: w_final};
    if (acc && hv_q) begin
      push_o.w0  = w_cont;
      push_o.num = (last_i && hv_after) ? 2'd2 : 2'd1;
    end else if (last_i && hv_after) begin
      push_o.num = 2'd1;
    end
    if (!fire_i) begin
      push_o.num = 2'd0;
    end
  end

  // Next state; end of string clears all but the held code
  always_comb begin
    cnt_d = (acc && cnt_q < CntMax) ? cnt_q + 5'd1 : cnt_q;
    hv_d  = hv_after;
    hc_d  = hc_after;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      skip_q <= '0;
      coll_q <= '0;
      part_q <= '0;
      cnt_q  <= '0;
      hv_q   <= 1'b0;
    end else if (fire_i) begin
      if (last_i) begin
        skip_q <= '0;
        coll_q <= '0;
        part_q <= '0;
        cnt_q  <= '0;
        hv_q   <= 1'b0;
      end else begin
        skip_q <= skip_d;
        coll_q <= coll_d;
        part_q <= part_d;
        cnt_q  <= cnt_d;
        hv_q   <= hv_d;
      end
    end
  end

  // Held code, read only while hv_q is set
  always_ff @(posedge clk_i) begin
    if (fire_i) begin
      hc_q <= hc_d;
    end
  end

endmodule

@@ rtl/u2lcd_outq.sv @@
// ----------------------------------------------------------------------------
// u2lcd_outq
// Small queue: takes up to two words a cycle, gives one a cycle on ready_i.
// ----------------------------------------------------------------------------
module u2lcd_outq (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  u2lcd_pkg::push_t  push_i,
  output logic              valid_o,
  input  logic              ready_i,
  output u2lcd_pkg::res_t   word_o,
  output u2lcd_pkg::qstat_t stat_o
);
  import u2lcd_pkg::*;

  res_t             mem_q [QDepth];
  logic [QPtrW-1:0] wr_q, rd_q;
  logic [QCntW-1:0] cnt_q;
  logic             pop;

  assign valid_o = (cnt_q != '0);
  assign pop     = valid_o && ready_i;
  assign word_o  = mem_q[rd_q];
  assign stat_o  = '{count: cnt_q, room: (cnt_q <= QCntW'(QDepth - 2))};

  // Storage
  always_ff @(posedge clk_i) begin
    if (push_i.num != 2'd0) begin
      mem_q[wr_q] <= push_i.w0;
    end
    if (push_i.num == 2'd2) begin
      mem_q[wr_q + QPtrW'(1)] <= push_i.w1;
    end
  end

  // Pointers and fill level
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_q + QPtrW'(push_i.num);
      rd_q  <= rd_q + QPtrW'(pop);
      cnt_q <= cnt_q + QCntW'(push_i.num) - QCntW'(pop);
    end
  end

endmodule

@@ rtl/utf8_to_lcd_charset_framer_top.sv @@
// ----------------------------------------------------------------------------
// utf8_to_lcd_charset_framer_top
// UTF-8 to LCD charset framer: one display code per character, for the
// first ROW_CHARS of a string, sent as control/data word pairs, last marked.
// ----------------------------------------------------------------------------
// Usage:
//   Slave stream carries the raw UTF-8 bytes, tlast on the final byte of a
//   string. Master stream carries one control/data pair per word, tlast on
//   the string's final pair. Registers are written through cfg_we_i, cfg_idx_i
//   and cfg_data_i while the block is idle: a user rule, not enforced here.
// Throughput: one byte per cycle while the queue has room. Each byte yields
//   at most one word, the final byte of a string up to two; the output port
//   drains one word per cycle with tready_i high; the result queue takes the rest.
// Path: a byte is taken into the input register, then decoded into the
//   queue, from which the word it releases is valid on the master side.
// Each code is held back by one character, so a word normally comes out
//   with the next character or at the end of the string.
// Stall: the four-entry result queue fills while tready_i is low; the byte
//   register stops once fewer than two entries are free, then tready_o drops.
// Reset clears the decoder state, the queue and sets control byte 0x40 and
//   continuation mask 0x80.
// ----------------------------------------------------------------------------
module utf8_to_lcd_charset_framer_top #(
  parameter int unsigned ROW_CHARS = 16
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  // [7:0] in_byte
  input  logic [7:0]  s_axis_tdata_i,
  input  logic        s_axis_tlast_i,
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  // [7:0] control_byte, [15:8] data_byte
  output logic [15:0] m_axis_tdata_o,
  output logic        m_axis_tlast_o,
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  input  logic        cfg_we_i,
  input  logic        cfg_idx_i,
  input  logic [7:0]  cfg_data_i
);
  import u2lcd_pkg::*;

  logic [7:0] data_ctl_q, cont_mask_q;
  logic       in_vld_q;
  logic [7:0] in_byte_q;
  logic       in_last_q;
  logic       fire;
  push_t      push;
  qstat_t     qstat;
  res_t       word;

  // Configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      data_ctl_q  <= DataCtlReset;
      cont_mask_q <= ContMaskReset;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CfgDataCtl:  data_ctl_q  <= cfg_data_i;
        CfgContMask: cont_mask_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // Input register
  assign fire            = in_vld_q && qstat.room;
  assign s_axis_tready_o = !in_vld_q || fire;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
    end else if (s_axis_tready_o) begin
      in_vld_q <= s_axis_tvalid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tready_o && s_axis_tvalid_i) begin
      in_byte_q <= s_axis_tdata_i;
      in_last_q <= s_axis_tlast_i;
    end
  end

  u2lcd_decode #(
    .ROW_CHARS (ROW_CHARS)
  ) u_decode (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .fire_i      (fire),
    .byte_i      (in_byte_q),
    .last_i      (in_last_q),
    .data_ctl_i  (data_ctl_q),
    .cont_mask_i (cont_mask_q),
    .push_o      (push)
  );

  u2lcd_outq u_outq (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .valid_o (m_axis_tvalid_o),
    .ready_i (m_axis_tready_i),
    .word_o  (word),
    .stat_o  (qstat)
  );

  assign m_axis_tdata_o = {word.data, word.ctrl};
  assign m_axis_tlast_o = word.eom;

  // Checks
  `include "utf8_to_lcd_charset_framer_top_assert.svh"

  `U2LCD_ASSERT_NOW(a_push_fits, push.num != 2'd0, qstat.count <= QCntW'(QDepth - 2), "queue overrun")
  `U2LCD_ASSERT_NOW(a_two_only_last, push.num == 2'd2, in_last_q && fire, "two words not at end of string")
  `U2LCD_ASSERT_NEXT(a_byte_held, in_vld_q && !fire, in_vld_q, "pending byte lost")

endmodule
